FILE: hw/rtl/lpsi_pkg.sv
`timescale 1ns / 1ps

package lpsi_pkg;

  // Serial-number half range: a forward distance at or above this is "older".
  localparam logic [31:0] SerialHalf = 32'h8000_0000;

  typedef enum logic {
    OP_RECORD = 1'b0,
    OP_READ   = 1'b1
  } op_e;

  typedef enum logic {
    REG_LOG_START = 1'b0,
    REG_LOG_END   = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_READ_FAILED = 3'd1,
    ST_BAD_LENGTH  = 3'd2,
    ST_SLOT_RANGE  = 3'd3,
    ST_AMBIGUOUS   = 3'd4,
    ST_HALTED      = 3'd5
  } status_e;

  typedef struct packed {
    op_e         operation;
    logic        record_ok;
    logic        is_save_record;
    logic        identity_match;
    logic [7:0]  slot;
    logic [31:0] generation;
    logic [15:0] sector_count;
  } in_t;

  typedef struct packed {
    status_e     status;
    logic [15:0] cursor;
    logic        log_complete;
    logic        slot_present;
    logic [15:0] slot_sector;
    logic [31:0] slot_generation;
  } out_t;

  typedef struct packed {
    logic [15:0] sector;
    logic [31:0] generation;
  } slot_entry_t;

endpackage

FILE: hw/rtl/lpsi_slot_table.sv
`timescale 1ns / 1ps

module lpsi_slot_table
  import lpsi_pkg::*;
#(
  parameter int unsigned SLOTS = 8,
  localparam int unsigned IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            clear_i,
  input  logic            rd_en_i,
  input  logic [IdxW-1:0] rd_addr_i,
  input  logic            wr_en_i,
  input  logic [IdxW-1:0] wr_addr_i,
  input  slot_entry_t     wr_data_i,
  output logic            rd_present_o,
  output slot_entry_t     rd_data_o
);

  slot_entry_t mem_q [SLOTS];
  logic [SLOTS-1:0] present_q;
  logic             rd_present_q;
  slot_entry_t      rd_data_q;
  logic             bypass;

  // Same-edge write to the address being read: hand over the new entry.
  assign bypass = wr_en_i && (wr_addr_i == rd_addr_i);

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= bypass ? wr_data_i : mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q    <= '0;
      rd_present_q <= 1'b0;
    end else if (clear_i) begin
      present_q    <= '0;
      rd_present_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        present_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_present_q <= bypass | present_q[rd_addr_i];
      end
    end
  end

  assign rd_present_o = rd_present_q;
  assign rd_data_o    = rd_data_q;

endmodule

FILE: hw/rtl/log_latest_per_slot_indexer.sv
`timescale 1ns / 1ps

// Latest-record-per-slot indexer. Feed it the decoded record headers of an
// append-only log, one beat each, and it tracks the log cursor and keeps the
// newest save record per slot (32-bit serial-number order with wraparound);
// a read beat returns one slot's entry. It takes one beat per clock unless
// the result register is full and stalled, and returns one result beat per
// input beat; each beat passes through the input register, where the slot
// entry is fetched from the table memory, and then the result register.
// Each beat does one read, compare and write of a slot entry plus the cursor
// add. The first bad record halts the walk (status 5) until the log start
// register is written again; that write reloads the cursor and empties the
// table through per-slot valid bits, so there is no clearing pass.
// Write the configuration registers only while no beat is in flight.
module log_latest_per_slot_indexer
  import lpsi_pkg::*;
#(
  parameter int unsigned SLOTS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_t        out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  cfg_reg_e    cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int unsigned IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // Control and architectural state
  logic        s1_valid_q, s1_valid_d;
  in_t         s1_data_q;
  logic        out_valid_q, out_valid_d;
  out_t        out_data_q, out_data_d;
  logic [15:0] cursor_q, cursor_d;
  logic        failed_q, failed_d;
  logic [15:0] end_q;

  logic        accept, advance, cfg_we, start_we;

  // Table interface
  logic        tbl_wr_en;
  slot_entry_t tbl_wr_data;
  logic        tbl_present;
  slot_entry_t tbl_entry;

  // Compute stage
  logic        in_range, hdr_entry, bad_len, newer, same_gen_other;
  logic [15:0] left;
  logic [31:0] gen_dist;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign start_we    = cfg_we && (cfg_index_i == REG_LOG_START);

  // Advance the compute stage whenever the result register frees up.
  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  lpsi_slot_table #(
    .SLOTS(SLOTS)
  ) u_table (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clear_i     (start_we),
    .rd_en_i     (accept),
    .rd_addr_i   (in_data_i.slot[IdxW-1:0]),
    .wr_en_i     (tbl_wr_en),
    .wr_addr_i   (s1_data_q.slot[IdxW-1:0]),
    .wr_data_i   (tbl_wr_data),
    .rd_present_o(tbl_present),
    .rd_data_o   (tbl_entry)
  );

  // Record checks, all off the input register and the fetched entry.
  assign in_range       = s1_data_q.slot < 8'(SLOTS);
  assign hdr_entry      = s1_data_q.is_save_record && s1_data_q.identity_match;
  assign left           = (cursor_q < end_q) ? (end_q - cursor_q) : 16'd0;
  assign bad_len        = (s1_data_q.sector_count == 16'd0) ||
                          (s1_data_q.sector_count > left);
  assign gen_dist       = s1_data_q.generation - tbl_entry.generation;
  assign newer          = (gen_dist != 32'd0) && (gen_dist < SerialHalf);
  assign same_gen_other = (s1_data_q.generation == tbl_entry.generation) &&
                          (cursor_q != tbl_entry.sector);

  assign tbl_wr_data = '{sector: cursor_q, generation: s1_data_q.generation};

  always_comb begin
    logic [2:0] st;
    logic       wr;
    logic       fail;
    logic [15:0] cur;
    st   = ST_OK;
    wr   = 1'b0;
    fail = failed_q;
    cur  = cursor_q;
    out_data_d = '0;

    if (s1_data_q.operation == OP_RECORD) begin
      if (failed_q) begin
        st = ST_HALTED;
      end else if (!s1_data_q.record_ok) begin
        st   = ST_READ_FAILED;
        fail = 1'b1;
      end else if (bad_len) begin
        st   = ST_BAD_LENGTH;
        fail = 1'b1;
      end else if (hdr_entry && !in_range) begin
        st   = ST_SLOT_RANGE;
        fail = 1'b1;
      end else if (hdr_entry && (!tbl_present || newer)) begin
        wr  = 1'b1;
        cur = cursor_q + s1_data_q.sector_count;
      end else if (hdr_entry && same_gen_other) begin
        st   = ST_AMBIGUOUS;
        fail = 1'b1;
      end else begin
        cur = cursor_q + s1_data_q.sector_count;
      end
    end else begin
      if (!in_range) begin
        st = ST_SLOT_RANGE;
      end else begin
        st = failed_q ? ST_HALTED : ST_OK;
        out_data_d.slot_present    = tbl_present;
        // Drop stale memory data behind a cleared valid bit.
        out_data_d.slot_sector     = tbl_present ? tbl_entry.sector : 16'd0;
        out_data_d.slot_generation = tbl_present ? tbl_entry.generation : 32'd0;
      end
    end

    out_data_d.status       = status_e'(st);
    out_data_d.cursor       = cur;
    out_data_d.log_complete = !fail && (cur == end_q);

    tbl_wr_en = s1_valid_q && advance && wr;
    cursor_d  = cur;
    failed_d  = fail;
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_data_q <= in_data_i;
    end
    if (advance && s1_valid_q) begin
      out_data_q <= out_data_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      cursor_q    <= 16'd0;
      failed_q    <= 1'b0;
      end_q       <= 16'd0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (advance && s1_valid_q) begin
        cursor_q <= cursor_d;
        failed_q <= failed_d;
      end
      if (cfg_we) begin
        unique case (cfg_index_i)
          REG_LOG_START: begin
            cursor_q <= cfg_data_i;
            failed_q <= 1'b0;
          end
          REG_LOG_END: begin
            end_q <= cfg_data_i;
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Once halted, only a restart moves the cursor.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    failed_q && !start_we |=> $stable(cursor_q))
  else $error("cursor moved while halted");

  // A rejected record header always leaves the walk halted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && s1_valid_q && (s1_data_q.operation == OP_RECORD) &&
    (out_data_d.status == ST_READ_FAILED || out_data_d.status == ST_BAD_LENGTH ||
     out_data_d.status == ST_SLOT_RANGE || out_data_d.status == ST_AMBIGUOUS) &&
    !cfg_we |=> failed_q)
  else $error("rejected record did not halt the walk");

  // Table writes only target slots that exist, and never while halted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tbl_wr_en |-> in_range && !failed_q)
  else $error("table write to an invalid slot or while halted");

  // A complete log never comes with a halting status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.log_complete |->
    (out_data_o.status == ST_OK || out_data_o.status == ST_SLOT_RANGE))
  else $error("log complete reported with a failure status");

endmodule
